// ===== rtl/bitmap_page_allocator_top_assert.svh =====
// Assertion macros used by bpa_ctrl, the sequencer of the bitmap page allocator.
// The macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
// Package for the bitmap page allocator: widths, codes and helper functions.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES_DEF = 65536;
    localparam int FRAME_W       = 36;
    localparam int COUNT_W       = 17;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [COUNT_W-1:0] WINDOW_PAGES_RST = 17'h10000;

    typedef enum logic [2:0] {
        ST_ALLOCATED     = 3'd0,
        ST_NONE_FREE     = 3'd1,
        ST_REFUSED_LARGE = 3'd2,
        ST_FREED         = 3'd3,
        ST_FREE_IGNORED  = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_BASE_FRAME   = 1'b0,
        REG_WINDOW_PAGES = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_TOP,
        S_ALLOC_SUM,
        S_ALLOC_MAP,
        S_FREE_CHECK,
        S_FREE_MAP
    } t_state;

    typedef struct packed {
        logic map_rd;
        logic map_wr;
        logic sum_rd;
        logic sum_wr;
        logic top_set;
        logic top_clr;
    } t_store_cmd;

    // Position of the lowest set bit of a word, found by isolating that bit.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] iso;
        logic [BIT_W-1:0]  pos;
        iso = w & (~w + 64'd1);
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (iso[i]) begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bpa_cfg.sv =====
// APB register file of the bitmap page allocator: base frame and managed page count.
// Depends on bpa_pkg.
`default_nettype none

module bpa_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bpa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [bpa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output logic      [bpa_pkg::FRAME_W-1:0]        o_base_frame,
    output logic      [bpa_pkg::COUNT_W-1:0]        o_window_pages
);

    logic [bpa_pkg::FRAME_W-1:0] r_base_frame;
    logic [bpa_pkg::COUNT_W-1:0] r_window_pages;
    bpa_pkg::t_reg_idx           reg_idx;
    logic                        wr_en;

    assign reg_idx = bpa_pkg::t_reg_idx'(paddr[3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_frame   <= '0;
            r_window_pages <= bpa_pkg::WINDOW_PAGES_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bpa_pkg::REG_BASE_FRAME:   r_base_frame   <= pwdata[bpa_pkg::FRAME_W-1:0];
                bpa_pkg::REG_WINDOW_PAGES: r_window_pages <= pwdata[bpa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bpa_pkg::REG_BASE_FRAME:   prdata = bpa_pkg::CFG_DATA_W'(r_base_frame);
            bpa_pkg::REG_WINDOW_PAGES: prdata = bpa_pkg::CFG_DATA_W'(r_window_pages);
            default:                   prdata = '0;
        endcase
    end

    assign o_base_frame   = r_base_frame;
    assign o_window_pages = r_window_pages;

endmodule

`default_nettype wire

// ===== rtl/bpa_store.sv =====
// Free-map storage: the page bit map memory, the word summary memory and the
// top summary vector, with the clearing sweep after reset. Depends on bpa_pkg.
`default_nettype none

module bpa_store #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
    localparam int MAP_WORDS = (NUM_PAGES + 63) / 64,
    localparam int SUM_WORDS = (MAP_WORDS + 63) / 64,
    localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int SW_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bpa_pkg::t_store_cmd              i_cmd,
    input  wire logic [MW_W-1:0]                  i_map_addr,
    input  wire logic [bpa_pkg::WORD_W-1:0]       i_map_wdata,
    input  wire logic [SW_W-1:0]                  i_sum_addr,
    input  wire logic [bpa_pkg::WORD_W-1:0]       i_sum_wdata,
    input  wire logic [SW_W-1:0]                  i_top_idx,
    output logic      [bpa_pkg::WORD_W-1:0]       o_map_rdata,
    output logic      [bpa_pkg::WORD_W-1:0]       o_sum_rdata,
    output logic      [SUM_WORDS-1:0]             o_top,
    output logic                                  o_ready
);

    localparam int SUM_REM = MAP_WORDS % 64;
    localparam logic [bpa_pkg::WORD_W-1:0] LAST_SUM_MASK =
        (SUM_REM == 0) ? '1 : ((64'd1 << SUM_REM) - 64'd1);

    logic [bpa_pkg::WORD_W-1:0] r_map_mem [MAP_WORDS];
    logic [bpa_pkg::WORD_W-1:0] r_sum_mem [SUM_WORDS];
    logic [bpa_pkg::WORD_W-1:0] r_map_rdata;
    logic [bpa_pkg::WORD_W-1:0] r_sum_rdata;
    logic [SUM_WORDS-1:0]       r_top;
    logic                       r_sweeping;
    logic [MW_W-1:0]            r_sweep_addr;
    logic                       sweep_sum;
    logic [bpa_pkg::WORD_W-1:0] sweep_sum_data;

    assign sweep_sum = {1'b0, r_sweep_addr} < (MW_W + 1)'(SUM_WORDS);
    assign sweep_sum_data = ({1'b0, r_sweep_addr} == (MW_W + 1)'(SUM_WORDS - 1)) ?
                            LAST_SUM_MASK : '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping   <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweeping) begin
            if ({1'b0, r_sweep_addr} == (MW_W + 1)'(MAP_WORDS - 1)) begin
                r_sweeping <= 1'b0;
            end
            r_sweep_addr <= r_sweep_addr + MW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweeping) begin
            r_map_mem[r_sweep_addr] <= '1;
        end else if (i_cmd.map_wr) begin
            r_map_mem[i_map_addr] <= i_map_wdata;
        end
        if (i_cmd.map_rd) begin
            r_map_rdata <= r_map_mem[i_map_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweeping) begin
            if (sweep_sum) begin
                r_sum_mem[r_sweep_addr[SW_W-1:0]] <= sweep_sum_data;
            end
        end else if (i_cmd.sum_wr) begin
            r_sum_mem[i_sum_addr] <= i_sum_wdata;
        end
        if (i_cmd.sum_rd) begin
            r_sum_rdata <= r_sum_mem[i_sum_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '1;
        end else if (i_cmd.top_set) begin
            r_top[i_top_idx] <= 1'b1;
        end else if (i_cmd.top_clr) begin
            r_top[i_top_idx] <= 1'b0;
        end
    end

    assign o_map_rdata = r_map_rdata;
    assign o_sum_rdata = r_sum_rdata;
    assign o_top       = r_top;
    assign o_ready     = !r_sweeping;

endmodule

`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
// Request sequencer of the bitmap page allocator: hierarchical first-fit search,
// free checks, read-modify-write of the free map and the result registers.
// Depends on bpa_pkg and bitmap_page_allocator_top_assert.svh.
`default_nettype none
`include "bitmap_page_allocator_top_assert.svh"

module bpa_ctrl #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
    localparam int MAP_WORDS = (NUM_PAGES + 63) / 64,
    localparam int SUM_WORDS = (MAP_WORDS + 63) / 64,
    localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int SW_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic                             i_cmd,
    input  wire logic [bpa_pkg::FRAME_W-1:0]      i_frame,
    input  wire logic                             i_source_large,
    input  wire logic [bpa_pkg::FRAME_W-1:0]      i_base_frame,
    input  wire logic [bpa_pkg::COUNT_W-1:0]      i_window_pages,
    output bpa_pkg::t_store_cmd                   o_store_cmd,
    output logic      [MW_W-1:0]                  o_map_addr,
    output logic      [bpa_pkg::WORD_W-1:0]       o_map_wdata,
    output logic      [SW_W-1:0]                  o_sum_addr,
    output logic      [bpa_pkg::WORD_W-1:0]       o_sum_wdata,
    output logic      [SW_W-1:0]                  o_top_idx,
    input  wire logic [bpa_pkg::WORD_W-1:0]       i_map_rdata,
    input  wire logic [bpa_pkg::WORD_W-1:0]       i_sum_rdata,
    input  wire logic [SUM_WORDS-1:0]             i_top,
    input  wire logic                             i_store_ready,
    output logic                                  o_done,
    output logic      [2:0]                       o_status,
    output logic      [bpa_pkg::FRAME_W-1:0]      o_granted_frame,
    output logic      [bpa_pkg::COUNT_W-1:0]      o_used_pages
);

    localparam int MWI_W = SW_W + 6;
    localparam logic [bpa_pkg::FRAME_W-1:0] NUM_PAGES_FW = bpa_pkg::FRAME_W'(NUM_PAGES);

    bpa_pkg::t_state             r_state, n_state;
    logic [bpa_pkg::FRAME_W-1:0] r_idx, n_idx;
    logic [SW_W-1:0]             r_sum_idx, n_sum_idx;
    logic [MWI_W-1:0]            r_mw, n_mw;
    logic [bpa_pkg::WORD_W-1:0]  r_sum_word, n_sum_word;
    logic                        r_done, n_done;
    bpa_pkg::t_status            r_status, n_status;
    logic [bpa_pkg::FRAME_W-1:0] r_granted, n_granted;
    logic [bpa_pkg::COUNT_W-1:0] r_used_count, n_used_count;

    bpa_pkg::t_store_cmd         store_cmd;
    logic                        accept;
    logic [bpa_pkg::FRAME_W-1:0] limit;
    logic [SUM_WORDS-1:0]        top_iso;
    logic [SW_W-1:0]             top_pick;
    logic [MWI_W-1:0]            mw_pick;
    logic [bpa_pkg::FRAME_W-1:0] alloc_idx;
    logic [bpa_pkg::WORD_W-1:0]  map_cleared;
    logic [bpa_pkg::WORD_W-1:0]  sum_cleared;

    assign o_busy = (r_state != bpa_pkg::S_IDLE) || !i_store_ready;
    assign accept = i_start && !o_busy;
    assign limit  = (bpa_pkg::FRAME_W'(i_window_pages) > NUM_PAGES_FW) ?
                    NUM_PAGES_FW : bpa_pkg::FRAME_W'(i_window_pages);

    always_comb begin
        top_iso  = i_top & (~i_top + SUM_WORDS'(1));
        top_pick = '0;
        for (int i = 0; i < SUM_WORDS; i++) begin
            if (top_iso[i]) begin
                top_pick = top_pick | SW_W'(i);
            end
        end
    end

    assign mw_pick     = {r_sum_idx, bpa_pkg::lowest_set(i_sum_rdata)};
    assign alloc_idx   = bpa_pkg::FRAME_W'({r_mw, bpa_pkg::lowest_set(i_map_rdata)});
    assign map_cleared = i_map_rdata & (i_map_rdata - 64'd1);
    assign sum_cleared = r_sum_word & (r_sum_word - 64'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpa_pkg::S_IDLE;
            r_done       <= 1'b0;
            r_used_count <= '0;
        end else begin
            r_state      <= n_state;
            r_done       <= n_done;
            r_used_count <= n_used_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_sum_idx  <= n_sum_idx;
        r_mw       <= n_mw;
        r_sum_word <= n_sum_word;
        r_status   <= n_status;
        r_granted  <= n_granted;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_sum_idx    = r_sum_idx;
        n_mw         = r_mw;
        n_sum_word   = r_sum_word;
        n_done       = 1'b0;
        n_status     = r_status;
        n_granted    = r_granted;
        n_used_count = r_used_count;
        store_cmd    = '0;
        o_map_addr   = '0;
        o_map_wdata  = '0;
        o_sum_addr   = '0;
        o_sum_wdata  = '0;
        o_top_idx    = '0;
        unique case (r_state)
            bpa_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx = i_frame - i_base_frame;
                    if (i_cmd == bpa_pkg::CMD_FREE) begin
                        n_state = bpa_pkg::S_FREE_CHECK;
                    end else if (i_source_large) begin
                        n_done    = 1'b1;
                        n_status  = bpa_pkg::ST_REFUSED_LARGE;
                        n_granted = '0;
                    end else begin
                        n_state = bpa_pkg::S_ALLOC_TOP;
                    end
                end
            end
            bpa_pkg::S_ALLOC_TOP: begin
                if (i_top == '0) begin
                    n_state   = bpa_pkg::S_IDLE;
                    n_done    = 1'b1;
                    n_status  = bpa_pkg::ST_NONE_FREE;
                    n_granted = '0;
                end else begin
                    n_sum_idx        = top_pick;
                    store_cmd.sum_rd = 1'b1;
                    o_sum_addr       = top_pick;
                    n_state          = bpa_pkg::S_ALLOC_SUM;
                end
            end
            bpa_pkg::S_ALLOC_SUM: begin
                n_sum_word       = i_sum_rdata;
                n_mw             = mw_pick;
                store_cmd.map_rd = 1'b1;
                o_map_addr       = mw_pick[MW_W-1:0];
                n_state          = bpa_pkg::S_ALLOC_MAP;
            end
            bpa_pkg::S_ALLOC_MAP: begin
                n_state = bpa_pkg::S_IDLE;
                n_done  = 1'b1;
                if (alloc_idx < limit) begin
                    store_cmd.map_wr = 1'b1;
                    o_map_addr       = r_mw[MW_W-1:0];
                    o_map_wdata      = map_cleared;
                    if (map_cleared == '0) begin
                        store_cmd.sum_wr = 1'b1;
                        o_sum_addr       = r_sum_idx;
                        o_sum_wdata      = sum_cleared;
                        if (sum_cleared == '0) begin
                            store_cmd.top_clr = 1'b1;
                            o_top_idx         = r_sum_idx;
                        end
                    end
                    n_used_count = r_used_count + bpa_pkg::COUNT_W'(1);
                    n_status     = bpa_pkg::ST_ALLOCATED;
                    n_granted    = i_base_frame + alloc_idx;
                end else begin
                    n_status  = bpa_pkg::ST_NONE_FREE;
                    n_granted = '0;
                end
            end
            bpa_pkg::S_FREE_CHECK: begin
                if (r_idx < limit) begin
                    store_cmd.map_rd = 1'b1;
                    store_cmd.sum_rd = 1'b1;
                    o_map_addr       = r_idx[6 +: MW_W];
                    o_sum_addr       = r_idx[12 +: SW_W];
                    n_state          = bpa_pkg::S_FREE_MAP;
                end else begin
                    n_state   = bpa_pkg::S_IDLE;
                    n_done    = 1'b1;
                    n_status  = bpa_pkg::ST_FREE_IGNORED;
                    n_granted = '0;
                end
            end
            bpa_pkg::S_FREE_MAP: begin
                n_state   = bpa_pkg::S_IDLE;
                n_done    = 1'b1;
                n_granted = '0;
                if (!i_map_rdata[r_idx[5:0]]) begin
                    store_cmd.map_wr  = 1'b1;
                    store_cmd.sum_wr  = 1'b1;
                    store_cmd.top_set = 1'b1;
                    o_map_addr        = r_idx[6 +: MW_W];
                    o_map_wdata       = i_map_rdata | (64'd1 << r_idx[5:0]);
                    o_sum_addr        = r_idx[12 +: SW_W];
                    o_sum_wdata       = i_sum_rdata | (64'd1 << r_idx[11:6]);
                    o_top_idx         = r_idx[12 +: SW_W];
                    n_used_count      = r_used_count - bpa_pkg::COUNT_W'(1);
                    n_status          = bpa_pkg::ST_FREED;
                end else begin
                    n_status = bpa_pkg::ST_FREE_IGNORED;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_store_cmd     = store_cmd;
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_frame = r_granted;
    assign o_used_pages    = r_used_count;

    `BPA_ASSERT_NOW(a_grant_only_on_alloc, r_done && (r_status != bpa_pkg::ST_ALLOCATED),
                    r_granted == '0, "Granted frame is nonzero on a non-allocating result.")
    `BPA_ASSERT_NOW(a_map_write_after_read, store_cmd.map_wr, $past(store_cmd.map_rd),
                    "Free map word written without a preceding read.")
    `BPA_ASSERT_NOW(a_top_clear_with_words, store_cmd.top_clr,
                    store_cmd.sum_wr && store_cmd.map_wr,
                    "Top summary bit cleared without emptying its words.")
    `BPA_ASSERT_NOW(a_count_moves_on_result, !$stable(r_used_count), r_done,
                    "Page count changed without a result.")
    `BPA_ASSERT_NEXT(a_search_descends, (r_state == bpa_pkg::S_ALLOC_TOP) && (i_top != '0),
                     r_state == bpa_pkg::S_ALLOC_SUM,
                     "Search did not descend to the summary word.")

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_allocator_top.sv =====
// Top level of the bitmap first-fit page allocator.
// Depends on bpa_pkg, bpa_cfg, bpa_store and bpa_ctrl.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low; i_cmd selects allocate or free, i_frame is the frame to free and
// i_source_large refuses an allocate. Every transaction yields one result on
// o_status, o_granted_frame and o_used_pages, marked by o_done for exactly
// one cycle. The receiver cannot stall; results are never held.
// An allocate reads the top summary vector, then one summary word, then one map
// word, and writes back through the single port of each memory. When the top
// summary vector is empty an allocate ends after the top read. A free ends
// early when the frame lies outside the window, and a refused allocate ends
// at its acceptance. The result appears in the cycle after the last step, in
// which the next transaction can already be accepted.
// After reset the free map memory is swept to all free, one 64-page word per
// cycle; busy stays high meanwhile.
// The user must write the APB registers base frame (0x0) and managed page count
// (0x8) only while no transaction is in flight; the block does not enforce it.
`default_nettype none

module bitmap_page_allocator_top #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
    localparam int MAP_WORDS = (NUM_PAGES + 63) / 64,
    localparam int SUM_WORDS = (MAP_WORDS + 63) / 64,
    localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int SW_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_cmd,
    input  wire logic [bpa_pkg::FRAME_W-1:0]      i_frame,
    input  wire logic                             i_source_large,
    output logic                                  o_done,
    output logic      [2:0]                       o_status,
    output logic      [bpa_pkg::FRAME_W-1:0]      o_granted_frame,
    output logic      [bpa_pkg::COUNT_W-1:0]      o_used_pages,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bpa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [bpa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    logic [bpa_pkg::FRAME_W-1:0] base_frame;
    logic [bpa_pkg::COUNT_W-1:0] window_pages;
    bpa_pkg::t_store_cmd         store_cmd;
    logic [MW_W-1:0]             map_addr;
    logic [bpa_pkg::WORD_W-1:0]  map_wdata;
    logic [SW_W-1:0]             sum_addr;
    logic [bpa_pkg::WORD_W-1:0]  sum_wdata;
    logic [SW_W-1:0]             top_idx;
    logic [bpa_pkg::WORD_W-1:0]  map_rdata;
    logic [bpa_pkg::WORD_W-1:0]  sum_rdata;
    logic [SUM_WORDS-1:0]        top_vec;
    logic                        store_ready;

    bpa_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_base_frame   (base_frame),
        .o_window_pages (window_pages)
    );

    bpa_store #(
        .NUM_PAGES (NUM_PAGES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (store_cmd),
        .i_map_addr  (map_addr),
        .i_map_wdata (map_wdata),
        .i_sum_addr  (sum_addr),
        .i_sum_wdata (sum_wdata),
        .i_top_idx   (top_idx),
        .o_map_rdata (map_rdata),
        .o_sum_rdata (sum_rdata),
        .o_top       (top_vec),
        .o_ready     (store_ready)
    );

    bpa_ctrl #(
        .NUM_PAGES (NUM_PAGES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_cmd           (i_cmd),
        .i_frame         (i_frame),
        .i_source_large  (i_source_large),
        .i_base_frame    (base_frame),
        .i_window_pages  (window_pages),
        .o_store_cmd     (store_cmd),
        .o_map_addr      (map_addr),
        .o_map_wdata     (map_wdata),
        .o_sum_addr      (sum_addr),
        .o_sum_wdata     (sum_wdata),
        .o_top_idx       (top_idx),
        .i_map_rdata     (map_rdata),
        .i_sum_rdata     (sum_rdata),
        .i_top           (top_vec),
        .i_store_ready   (store_ready),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_frame (o_granted_frame),
        .o_used_pages    (o_used_pages)
    );

endmodule

`default_nettype wire
